### hdl/tdm_slot_to_pcm16_remap_assert.svh
// assertion macros shared by the remap block
`ifndef TDM_SLOT_TO_PCM16_REMAP_ASSERT_SVH
`define TDM_SLOT_TO_PCM16_REMAP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TDMR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TDMR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tdmr_pkg.sv
// ----------------------------------------------------------------------------
// tdmr_pkg
// shared widths, register indexes and control types of the slot remap block
// ----------------------------------------------------------------------------
package tdmr_pkg;

    localparam int RAW_W         = 32;
    localparam int CFG_W         = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int PCM_W         = 16;
    localparam int SRC_W         = 2;
    localparam int NUM_CH        = 4;
    localparam int CH_W          = 2;
    localparam int CNT_W         = $clog2(NUM_CH + 1);
    localparam int KEEP_W        = $clog2(PCM_W + 1);

    localparam int SLOT_BITS_DEF = 32;
    localparam int NUM_SLOTS_DEF = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_BITS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC0       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC1       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC2       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC3       = 3'd5;

    // reset values
    localparam logic [CFG_W-1:0] RST_VALID_BITS = 6'd24;
    localparam logic [CFG_W-1:0] RST_OFFSET     = 6'd0;

    localparam logic [CH_W-1:0] CH_LAST = 2'd3;

    // slot write strobe from the decode stage to the frame buffer
    typedef struct packed {
        logic wr;
        logic last;
    } t_slot_ctl;

endpackage

### hdl/tdmr_decode.sv
// ----------------------------------------------------------------------------
// tdmr_decode
// aligns one slot word and scales its valid bits to a pcm16 sample
// ----------------------------------------------------------------------------
module tdmr_decode #(
    parameter int SLOT_BITS = tdmr_pkg::SLOT_BITS_DEF
) (
    input  logic [tdmr_pkg::RAW_W-1:0]        i_raw_word,
    input  logic [tdmr_pkg::CFG_W-1:0]        i_valid_bits,
    input  logic signed [tdmr_pkg::CFG_W-1:0] i_offset,
    output logic signed [tdmr_pkg::PCM_W-1:0] o_sample
);
    import tdmr_pkg::*;

    logic [SLOT_BITS-1:0] w_slot;
    logic [SLOT_BITS-1:0] w_shift;
    logic [CFG_W-1:0]     w_mag;
    logic [KEEP_W-1:0]    w_keep;
    logic [PCM_W-1:0]     w_mask;

    assign w_slot = i_raw_word[SLOT_BITS-1:0];

    // magnitude of the negative offset, -32 gives 32
    assign w_mag = ~i_offset + 1'b1;

    // shifts past the slot width give zero
    always_comb begin
        if (i_offset[CFG_W-1]) begin
            w_shift = w_slot >> w_mag;
        end else begin
            w_shift = w_slot << i_offset;
        end
    end

    // the valid field is left-justified, so the top 16 bits already carry
    // the scaled value; only bits below a short valid width get cleared,
    // and the result never leaves the pcm16 range
    always_comb begin
        if (i_valid_bits == '0) begin
            w_keep = KEEP_W'(1);
        end else if (i_valid_bits >= CFG_W'(PCM_W)) begin
            w_keep = KEEP_W'(PCM_W);
        end else begin
            w_keep = i_valid_bits[KEEP_W-1:0];
        end
    end

    assign w_mask   = {PCM_W{1'b1}} << (KEEP_W'(PCM_W) - w_keep);
    assign o_sample = $signed(w_shift[SLOT_BITS-1 -: PCM_W] & w_mask);

endmodule

### hdl/tdmr_frame.sv
// ----------------------------------------------------------------------------
// tdmr_frame
// per-slot sample store, channel remap and four-entry output buffer
// ----------------------------------------------------------------------------
module tdmr_frame #(
    parameter int NUM_SLOTS = tdmr_pkg::NUM_SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tdmr_pkg::t_slot_ctl                 i_ctl,
    input  logic [$clog2(NUM_SLOTS)-1:0]        i_pos,
    input  logic signed [tdmr_pkg::PCM_W-1:0]   i_sample,
    input  logic [tdmr_pkg::SRC_W-1:0]          i_src [tdmr_pkg::NUM_CH],
    output logic                                o_load_ok,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [tdmr_pkg::PCM_W-1:0]   o_pcm_sample,
    output logic [tdmr_pkg::CH_W-1:0]           o_channel,
    output logic                                o_frame_last
);
    import tdmr_pkg::*;

    localparam int SIDX_W = $clog2(NUM_SLOTS);

    logic signed [PCM_W-1:0] r_slot [NUM_SLOTS];
    logic signed [PCM_W-1:0] r_ob   [NUM_CH];
    logic signed [PCM_W-1:0] n_ob   [NUM_CH];
    logic [CNT_W-1:0]        r_cnt;
    logic [SIDX_W-1:0]       w_idx  [NUM_CH];
    logic                    w_out_acc;
    logic                    w_load;

    assign w_out_acc = o_out_valid && !i_out_stall;
    assign o_load_ok = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && w_out_acc);
    assign w_load    = i_ctl.wr && i_ctl.last;

    // sources beyond the slot count read the last slot
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (int'(i_src[c]) >= NUM_SLOTS) begin
                w_idx[c] = SIDX_W'(NUM_SLOTS - 1);
            end else begin
                w_idx[c] = SIDX_W'(i_src[c]);
            end
            // the slot being written this cycle bypasses the store
            n_ob[c] = (w_idx[c] == i_pos) ? i_sample : r_slot[w_idx[c]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_slot[i_pos] <= i_sample;
        end
        if (w_load) begin
            r_ob <= n_ob;
        end else if (w_out_acc) begin
            for (int c = 0; c < NUM_CH - 1; c++) begin
                r_ob[c] <= r_ob[c + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_load) begin
            r_cnt <= CNT_W'(NUM_CH);
        end else if (w_out_acc) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_out_valid  = (r_cnt != '0);
    assign o_pcm_sample = r_ob[0];
    assign o_channel    = CH_W'(CNT_W'(NUM_CH) - r_cnt);
    assign o_frame_last = (r_cnt == CNT_W'(1));

endmodule

### hdl/tdm_slot_to_pcm16_remap.sv
// ----------------------------------------------------------------------------
// tdm_slot_to_pcm16_remap
// left-justified tdm slot words to remapped pcm16 channel samples
// ----------------------------------------------------------------------------
// pipeline: a word is held in the input register and is then decoded into
//   the slot store; the last slot of a frame also loads the output buffer,
//   from which channel zero appears once that word has been decoded
// throughput: one word, one result per cycle unless stalled; the four-entry
//   output buffer sets the pace, so frames shorter than four slots stall input
// reset: clears slot position, buffer count and input valid, loads register
//   defaults; the slot store is not cleared
// ----------------------------------------------------------------------------
module tdm_slot_to_pcm16_remap #(
    parameter int SLOT_BITS = tdmr_pkg::SLOT_BITS_DEF,
    parameter int NUM_SLOTS = tdmr_pkg::NUM_SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [tdmr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tdmr_pkg::CFG_W-1:0]          i_cfg_data,
    // slot word input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [tdmr_pkg::RAW_W-1:0]          i_raw_word,
    // sample output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [tdmr_pkg::PCM_W-1:0]   o_pcm_sample,
    output logic [tdmr_pkg::CH_W-1:0]           o_channel,
    output logic                                o_frame_last
);
    import tdmr_pkg::*;
    `include "tdm_slot_to_pcm16_remap_assert.svh"

    localparam int SIDX_W = $clog2(NUM_SLOTS);

    // configuration registers
    logic [CFG_W-1:0]        r_valid_bits;
    logic signed [CFG_W-1:0] r_offset;
    logic [SRC_W-1:0]        r_src [NUM_CH];

    // input register
    logic                    r_in_valid;
    logic [RAW_W-1:0]        r_in_word;

    // slot position of the word in the input register
    logic [SIDX_W-1:0]       r_pos;

    logic                    w_in_acc;
    logic                    w_last;
    logic                    w_fire;
    logic                    w_load_ok;
    logic signed [PCM_W-1:0] w_sample;
    t_slot_ctl               w_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_bits <= RST_VALID_BITS;
            r_offset     <= RST_OFFSET;
            for (int c = 0; c < NUM_CH; c++) begin
                r_src[c] <= SRC_W'(c);
            end
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_VALID_BITS: r_valid_bits <= i_cfg_data;
                CFG_OFFSET:     r_offset     <= i_cfg_data;
                CFG_SRC0:       r_src[0]     <= i_cfg_data[SRC_W-1:0];
                CFG_SRC1:       r_src[1]     <= i_cfg_data[SRC_W-1:0];
                CFG_SRC2:       r_src[2]     <= i_cfg_data[SRC_W-1:0];
                CFG_SRC3:       r_src[3]     <= i_cfg_data[SRC_W-1:0];
                default: begin
                    // writes past the register list are dropped
                end
            endcase
        end
    end

    // a non-final slot always moves on; the final slot waits for the
    // output buffer to be empty or emptying this cycle
    assign w_last     = (r_pos == SIDX_W'(NUM_SLOTS - 1));
    assign w_fire     = r_in_valid && (!w_last || w_load_ok);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_word <= i_raw_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_fire) begin
            r_pos <= w_last ? '0 : r_pos + 1'b1;
        end
    end

    // word alignment and scaling
    tdmr_decode #(
        .SLOT_BITS   (SLOT_BITS)
    ) u_decode (
        .i_raw_word  (r_in_word),
        .i_valid_bits(r_valid_bits),
        .i_offset    (r_offset),
        .o_sample    (w_sample)
    );

    assign w_ctl.wr   = w_fire;
    assign w_ctl.last = w_last;

    // slot store, remap and output buffer
    tdmr_frame #(
        .NUM_SLOTS   (NUM_SLOTS)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_pos       (r_pos),
        .i_sample    (w_sample),
        .i_src       (r_src),
        .o_load_ok   (w_load_ok),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pcm_sample(o_pcm_sample),
        .o_channel   (o_channel),
        .o_frame_last(o_frame_last)
    );

    // frame end flag only ever rides on channel three
    `TDMR_ASSERT_IMP(a_last_on_ch3, o_out_valid && o_frame_last, o_channel == CH_LAST, "frame_last off channel three")
    // finishing a frame starts the output at channel zero
    `TDMR_ASSERT_NXT(a_frame_starts, w_fire && w_last, o_out_valid && (o_channel == '0), "frame output did not start")
    // a decoded non-final slot steps the slot position by one
    `TDMR_ASSERT_NXT(a_pos_step, w_fire && !w_last, r_pos == $past(r_pos) + 1'b1, "slot position skipped")

endmodule
